// ----- rtl/core/metg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package metg_pkg;

    localparam int MAX_ELEMENTS_DEF       = 8;
    localparam int UNIT_US_AT_ONE_WPM_DEF = 1200000;

    localparam int WPM_W     = 7;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int PAT_W     = 8;
    localparam int PAT_IDX_W = $clog2(PAT_W);
    localparam int LEN_W     = 4;
    localparam int UNIT_W    = 19;
    localparam int CORR_W    = UNIT_W + 1;
    localparam int DUR_W     = 21;
    localparam int QDEPTH    = 2;

    localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WPM   = 2'd0,
        CFG_COMP  = 2'd1,
        CFG_KCORR = 2'd2,
        CFG_INV   = 2'd3
    } t_cfg_idx;

    // One classified character: unit and clamped correction already worked out.
    typedef struct packed {
        logic              is_space;
        logic [PAT_W-1:0]  pattern;
        logic [LEN_W-1:0]  length;
        logic [UNIT_W-1:0] unit;
        logic [CORR_W-1:0] corr;
    } t_char;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- rtl/core/metg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module metg_front #(
    parameter int MAX_ELEMENTS       = metg_pkg::MAX_ELEMENTS_DEF,
    parameter int UNIT_US_AT_ONE_WPM = metg_pkg::UNIT_US_AT_ONE_WPM_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_is_word_space,
    input  wire logic [metg_pkg::PAT_W-1:0]     i_code_pattern,
    input  wire logic [metg_pkg::LEN_W-1:0]     i_code_length,
    input  wire logic [metg_pkg::WPM_W-1:0]     i_wpm,
    input  wire logic [metg_pkg::CFG_W-1:0]     i_comp,
    input  wire logic [metg_pkg::CFG_W-1:0]     i_kcorr,
    input  wire metg_pkg::t_q_stat              i_q_stat,
    output logic                                o_push,
    output metg_pkg::t_char                     o_char
);

    localparam int DW     = $clog2(UNIT_US_AT_ONE_WPM + 1);
    localparam int CNT_W  = $clog2(DW + 1);
    localparam int MAXW0  = (DW > metg_pkg::CFG_W) ? DW : metg_pkg::CFG_W;
    localparam int MAXW1  = (MAXW0 > metg_pkg::UNIT_W) ? MAXW0 : metg_pkg::UNIT_W;
    localparam int SW     = MAXW1 + 2;
    localparam int MAXLEN = (MAX_ELEMENTS < metg_pkg::PAT_W) ? MAX_ELEMENTS : metg_pkg::PAT_W;
    localparam logic [DW-1:0]                  DIVIDEND = DW'(UNIT_US_AT_ONE_WPM);
    localparam logic [metg_pkg::LEN_W-1:0]     LEN_CAP  = metg_pkg::LEN_W'(MAXLEN);
    localparam logic [CNT_W-1:0]               DIV_STEPS = CNT_W'(DW);

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_ADJ,
        F_CLAMP,
        F_PUSH
    } t_fstate;

    t_fstate                         r_state;
    logic                            r_space;
    logic [metg_pkg::PAT_W-1:0]      r_pat;
    logic [metg_pkg::LEN_W-1:0]      r_len;
    logic [metg_pkg::WPM_W-1:0]      r_dvs;
    logic [metg_pkg::WPM_W-1:0]      r_rem;
    logic [DW-1:0]                   r_quo;
    logic [CNT_W-1:0]                r_cnt;
    logic [metg_pkg::UNIT_W-1:0]     r_unit;
    logic [metg_pkg::CORR_W-1:0]     r_corr;

    logic [metg_pkg::LEN_W-1:0]      w_len_sat;
    logic [metg_pkg::WPM_W:0]        w_trial;
    logic [metg_pkg::WPM_W:0]        w_diff;
    logic                            w_ge;
    logic signed [SW-1:0]            w_quo_s;
    logic signed [SW-1:0]            w_comp_s;
    logic signed [SW-1:0]            w_umax_s;
    logic signed [SW-1:0]            w_adj;
    logic [metg_pkg::UNIT_W-1:0]     w_unit_sat;
    logic signed [metg_pkg::CORR_W-1:0] w_half;
    logic signed [metg_pkg::CORR_W-1:0] w_neg_half;
    logic signed [metg_pkg::CORR_W-1:0] w_kc;
    logic signed [metg_pkg::CORR_W-1:0] w_corr;

    assign w_len_sat = (i_code_length > LEN_CAP) ? LEN_CAP : i_code_length;

    // One restoring division step per cycle, quotient shifted in from the bottom.
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    assign w_quo_s  = $signed({{(SW-DW){1'b0}}, r_quo});
    assign w_comp_s = $signed({{(SW-metg_pkg::CFG_W){i_comp[metg_pkg::CFG_W-1]}}, i_comp});
    assign w_umax_s = $signed({{(SW-metg_pkg::UNIT_W){1'b0}}, metg_pkg::UNIT_MAX});
    assign w_adj    = (w_comp_s < w_quo_s) ? (w_quo_s - w_comp_s) : w_quo_s;
    assign w_unit_sat = (w_adj > w_umax_s) ? metg_pkg::UNIT_MAX : w_adj[metg_pkg::UNIT_W-1:0];

    assign w_half     = $signed({2'b00, r_unit[metg_pkg::UNIT_W-1:1]});
    assign w_neg_half = -w_half;
    assign w_kc = $signed({{(metg_pkg::CORR_W-metg_pkg::CFG_W){i_kcorr[metg_pkg::CFG_W-1]}},
                           i_kcorr});

    always_comb begin
        priority if (w_kc < w_neg_half) begin
            w_corr = w_neg_half;
        end else if (w_kc > w_half) begin
            w_corr = w_half;
        end else begin
            w_corr = w_kc;
        end
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_q_stat.full;

    assign o_char.is_space = r_space;
    assign o_char.pattern  = r_pat;
    assign o_char.length   = r_len;
    assign o_char.unit     = r_unit;
    assign o_char.corr     = r_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    // A pattern of length zero sends nothing and is dropped here.
                    if (i_start && (i_is_word_space || (i_code_length != '0))) begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= F_ADJ;
                    end
                end
                F_ADJ:   r_state <= F_CLAMP;
                F_CLAMP: r_state <= F_PUSH;
                F_PUSH: begin
                    if (!i_q_stat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_space <= i_is_word_space;
                r_pat   <= i_code_pattern;
                r_len   <= w_len_sat;
                r_dvs   <= (i_wpm == '0) ? metg_pkg::WPM_W'(1) : i_wpm;
                r_rem   <= '0;
                r_quo   <= DIVIDEND;
                r_cnt   <= DIV_STEPS;
            end
            F_DIV: begin
                r_rem <= w_ge ? w_diff[metg_pkg::WPM_W-1:0] : w_trial[metg_pkg::WPM_W-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            F_ADJ:   r_unit <= w_unit_sat;
            F_CLAMP: r_corr <= w_corr;
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    a_push_only_full_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == F_PUSH))
        else $error("front pushed outside its push state");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV) |-> (r_cnt != '0))
        else $error("divider ran with an exhausted step count");

    a_div_then_adj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == F_DIV) && (r_cnt == CNT_W'(1))) |=> (r_state == F_ADJ))
        else $error("divider did not hand over after its last step");

endmodule

`default_nettype wire

// ----- rtl/core/metg_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module metg_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire metg_pkg::t_char  i_wdata,
    input  wire logic             i_pop,
    output metg_pkg::t_char       o_rdata,
    output metg_pkg::t_q_stat     o_stat
);

    localparam int PTR_W = (metg_pkg::QDEPTH > 1) ? $clog2(metg_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(metg_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(metg_pkg::QDEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(metg_pkg::QDEPTH - 1);

    metg_pkg::t_char       r_mem [metg_pkg::QDEPTH];
    logic [PTR_W-1:0]      r_wr;
    logic [PTR_W-1:0]      r_rd;
    logic [CNT_W-1:0]      r_count;

    assign o_rdata      = r_mem[r_rd];
    assign o_stat.full  = (r_count == DEPTH_C);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_P) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_P) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ----- rtl/core/metg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module metg_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_key_inverted,
    input  wire metg_pkg::t_char              i_char,
    input  wire metg_pkg::t_q_stat            i_q_stat,
    output logic                              o_pop,
    output logic                              o_strobe,
    output logic                              o_key_level,
    output logic [metg_pkg::DUR_W-1:0]        o_duration_us,
    output logic                              o_last_segment
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_ON,
        B_OFF,
        B_SPACE
    } t_bstate;

    t_bstate                         r_state;
    logic [metg_pkg::PAT_W-1:0]      r_pat;
    logic [metg_pkg::LEN_W-1:0]      r_len;
    logic [metg_pkg::LEN_W-1:0]      r_idx;
    logic [metg_pkg::UNIT_W-1:0]     r_unit;
    logic [metg_pkg::CORR_W-1:0]     r_corr;
    logic [metg_pkg::DUR_W-1:0]      r_u3;
    logic [metg_pkg::DUR_W-1:0]      r_u4;
    logic                            r_strobe;
    logic                            r_level;
    logic [metg_pkg::DUR_W-1:0]      r_dur;
    logic                            r_last;

    logic signed [metg_pkg::DUR_W:0] w_unit_s;
    logic signed [metg_pkg::DUR_W:0] w_corr_s;
    logic signed [metg_pkg::DUR_W:0] w_plus;
    logic signed [metg_pkg::DUR_W:0] w_minus;
    logic [metg_pkg::DUR_W-1:0]      w_in_unit;
    logic                            w_dash;
    logic                            w_last;

    assign o_pop = (r_state == B_IDLE) && !i_q_stat.empty;

    assign w_in_unit = {{(metg_pkg::DUR_W-metg_pkg::UNIT_W){1'b0}}, i_char.unit};

    assign w_unit_s = $signed({{(metg_pkg::DUR_W+1-metg_pkg::UNIT_W){1'b0}}, r_unit});
    assign w_corr_s = $signed({{(metg_pkg::DUR_W+1-metg_pkg::CORR_W){r_corr[metg_pkg::CORR_W-1]}},
                               r_corr});
    assign w_plus  = w_unit_s + w_corr_s;
    assign w_minus = w_unit_s - w_corr_s;
    assign w_dash  = r_pat[r_idx[metg_pkg::PAT_IDX_W-1:0]];
    assign w_last  = (({1'b0, r_idx} + (metg_pkg::LEN_W+1)'(1)) == {1'b0, r_len});

    assign o_strobe       = r_strobe;
    assign o_key_level    = r_level;
    assign o_duration_us  = r_dur;
    assign o_last_segment = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    r_strobe <= 1'b0;
                    if (!i_q_stat.empty) begin
                        r_state <= i_char.is_space ? B_SPACE : B_ON;
                        r_pat   <= i_char.pattern;
                        r_len   <= i_char.length;
                        r_idx   <= '0;
                        r_unit  <= i_char.unit;
                        r_corr  <= i_char.corr;
                        r_u3    <= {w_in_unit[metg_pkg::DUR_W-2:0], 1'b0} + w_in_unit;
                        r_u4    <= {w_in_unit[metg_pkg::DUR_W-3:0], 2'b00};
                    end
                end
                B_ON: begin
                    r_strobe <= 1'b1;
                    r_level  <= ~i_key_inverted;
                    r_dur    <= w_dash ? r_u3 : w_plus[metg_pkg::DUR_W-1:0];
                    r_last   <= 1'b0;
                    r_state  <= B_OFF;
                end
                B_OFF: begin
                    r_strobe <= 1'b1;
                    r_level  <= i_key_inverted;
                    r_dur    <= w_last ? r_u3 : w_minus[metg_pkg::DUR_W-1:0];
                    r_last   <= w_last;
                    r_idx    <= r_idx + metg_pkg::LEN_W'(1);
                    r_state  <= w_last ? B_IDLE : B_ON;
                end
                B_SPACE: begin
                    r_strobe <= 1'b1;
                    r_level  <= i_key_inverted;
                    r_dur    <= r_u4;
                    r_last   <= 1'b1;
                    r_state  <= B_IDLE;
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= B_IDLE;
                end
            endcase
        end
    end

    // Segments of one character come out back to back; the last one ends the run.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_segment) |=> !o_strobe)
        else $error("segment followed the last segment of a character");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_segment) |=> (o_strobe && (o_key_level != $past(o_key_level))))
        else $error("character run broke off or did not alternate key level");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != B_IDLE))
        else $error("queue entry taken but no segments started");

endmodule

`default_nettype wire

// ----- rtl/core/morse_element_timing_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transfer                    Payload
// --------  ---------  --------------------------  ------------------------------------------
// item      in         start && !busy              i_is_word_space, i_code_pattern,
//                                                  i_code_length
// segment   out        o_strobe (one cycle)        o_key_level, o_duration_us, o_last_segment
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// The front holds busy through one divider step per bit of UNIT_US_AT_ONE_WPM (21 at the default),
// then adjustment, clamping and the queue write, which waits while the queue is full.
// The back loads a character while idle, then sends one segment a cycle (2 per element,
// 1 for a word space); a two-entry queue lets it run while the front works on the next one.
// A pattern of length zero is dropped in the cycle it is accepted and keeps busy low.
// Reset is synchronous and active low; it empties the queue and restores the register defaults.
// Segments cannot be held off by the receiver; a full queue stalls only the front.
module morse_element_timing_generator #(
    parameter int MAX_ELEMENTS       = metg_pkg::MAX_ELEMENTS_DEF,
    parameter int UNIT_US_AT_ONE_WPM = metg_pkg::UNIT_US_AT_ONE_WPM_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_is_word_space,
    input  wire logic [metg_pkg::PAT_W-1:0]       i_code_pattern,
    input  wire logic [metg_pkg::LEN_W-1:0]       i_code_length,
    input  wire logic                             i_cfg_we,
    input  wire logic [metg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [metg_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                                  o_strobe,
    output logic                                  o_key_level,
    output logic [metg_pkg::DUR_W-1:0]            o_duration_us,
    output logic                                  o_last_segment
);

    logic [metg_pkg::WPM_W-1:0]   r_wpm;
    logic [metg_pkg::CFG_W-1:0]   r_comp;
    logic [metg_pkg::CFG_W-1:0]   r_kcorr;
    logic                         r_inv;

    logic                         w_push;
    logic                         w_pop;
    metg_pkg::t_char              w_wchar;
    metg_pkg::t_char              w_rchar;
    metg_pkg::t_q_stat            w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpm   <= metg_pkg::WPM_W'(20);
            r_comp  <= '0;
            r_kcorr <= '0;
            r_inv   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                metg_pkg::CFG_WPM:   r_wpm   <= i_cfg_wdata[metg_pkg::WPM_W-1:0];
                metg_pkg::CFG_COMP:  r_comp  <= i_cfg_wdata;
                metg_pkg::CFG_KCORR: r_kcorr <= i_cfg_wdata;
                metg_pkg::CFG_INV:   r_inv   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    metg_front #(
        .MAX_ELEMENTS       (MAX_ELEMENTS),
        .UNIT_US_AT_ONE_WPM (UNIT_US_AT_ONE_WPM)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_is_word_space (i_is_word_space),
        .i_code_pattern  (i_code_pattern),
        .i_code_length   (i_code_length),
        .i_wpm           (r_wpm),
        .i_comp          (r_comp),
        .i_kcorr         (r_kcorr),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_char          (w_wchar)
    );

    metg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wchar),
        .i_pop   (w_pop),
        .o_rdata (w_rchar),
        .o_stat  (w_q_stat)
    );

    metg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_inverted (r_inv),
        .i_char         (w_rchar),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_key_level    (o_key_level),
        .o_duration_us  (o_duration_us),
        .o_last_segment (o_last_segment)
    );

endmodule

`default_nettype wire
